### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AST_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/hrcd_pkg.sv
// Types, codes and character tables of the HTTP chunked response decoder.
package hrcd_pkg;

   // parser phases
   localparam logic [2:0] PH_HEADER      = 3'd0;
   localparam logic [2:0] PH_PLAIN       = 3'd1;
   localparam logic [2:0] PH_SIZE_START  = 3'd2;
   localparam logic [2:0] PH_SIZE_DIGITS = 3'd3;
   localparam logic [2:0] PH_SKIP_LF     = 3'd4;
   localparam logic [2:0] PH_DATA        = 3'd5;
   localparam logic [2:0] PH_DONE        = 3'd6;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int MARKER_LEN        = 26;
   localparam int STATUS_MAX_DIGITS = 3;
   localparam int HEX_RADIX_BITS    = 4;

   // result tdata layout, lowest bit first
   localparam int RSP_DATA_BITS = 24;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.hit   = 1'b0;
      r.value = 4'd0;
      if (c >= "0" && c <= "9") begin
         r.hit   = 1'b1;
         r.value = c[3:0];
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         r.hit   = 1'b1;
         r.value = 4'(c[3:0] + 4'd9);
      end
      return r;
   endfunction

   // the text "Transfer-Encoding: chunked"
   function automatic logic [7:0] marker_char(input logic [4:0] idx);
      logic [7:0] ch;
      case (idx)
         5'd0:    ch = "T";
         5'd1:    ch = "r";
         5'd2:    ch = "a";
         5'd3:    ch = "n";
         5'd4:    ch = "s";
         5'd5:    ch = "f";
         5'd6:    ch = "e";
         5'd7:    ch = "r";
         5'd8:    ch = "-";
         5'd9:    ch = "E";
         5'd10:   ch = "n";
         5'd11:   ch = "c";
         5'd12:   ch = "o";
         5'd13:   ch = "d";
         5'd14:   ch = "i";
         5'd15:   ch = "n";
         5'd16:   ch = "g";
         5'd17:   ch = ":";
         5'd18:   ch = " ";
         5'd19:   ch = "c";
         5'd20:   ch = "h";
         5'd21:   ch = "u";
         5'd22:   ch = "n";
         5'd23:   ch = "k";
         5'd24:   ch = "e";
         5'd25:   ch = "d";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/core/http_response_chunked_decoder_top.sv
// HTTP response parser and chunked transfer decoder, one byte per transfer.
//
//   channel | direction | contents
//   --------+-----------+---------------------------------------------------
//   req_    | in        | tdata: response byte; tlast: final byte
//   rsp_    | out       | tdata: body byte, status, flags; tuser: body byte
//           |           | valid; tlast: result of the final byte
//
// Rate: one byte per clock while the output is not stalled; a result appears in the cycle
//   after the transfer of the byte that causes it, from the result register.
// The state update for a byte is done in the cycle it is transferred, so
//   bytes may follow each other in consecutive cycles.
// Reset: synchronous, active high; returns to the header phase.
// Stalls: req_tready is low only while a result waits and rsp_tready is low.
module http_response_chunked_decoder_top
   import hrcd_pkg::*;
#(
   parameter int SIZE_BITS = 32   // chunk size width, 16 to 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] in_byte
   input  logic                     req_tlast,   // is_last
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [7:0] out_byte, [17:8] status_code,
                                                 // [18] status_found, [19] header_found,
                                                 // [20] was_chunked, [23:21] zero
   output logic                     rsp_tuser,   // body_valid
   output logic                     rsp_tlast    // is_end
);

   // parser state
   logic [2:0]           phase_ff,          phase_in;
   logic [1:0]           end_match_ff,      end_match_in;
   logic [4:0]           marker_match_ff,   marker_match_in;
   logic                 chunked_seen_ff,   chunked_seen_in;
   logic [1:0]           space_count_ff,    space_count_in;
   logic [1:0]           status_digits_ff,  status_digits_in;
   logic                 status_stopped_ff, status_stopped_in;
   logic [9:0]           status_value_ff,   status_value_in;
   logic [SIZE_BITS-1:0] chunk_count_ff,    chunk_count_in;

   // result register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff;
   logic                     rsp_last_ff;

   logic                   accept;
   logic [7:0]             c;
   hex_digit_type          hex;
   logic [SIZE_BITS+3:0]   size_acc;
   logic [7:0]             end_char;
   logic                   body_valid;
   logic                   hdr_done;
   logic                   status_ok;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign hex        = hex_decode(c);
   // shift in one hex digit; a carry out of the top means the size saturates
   assign size_acc   = {chunk_count_ff, 4'b0000} + {{SIZE_BITS{1'b0}}, hex.value};
   assign end_char   = end_match_ff[0] ? CHAR_LF : CHAR_CR;

   always_comb begin
      phase_in          = phase_ff;
      end_match_in      = end_match_ff;
      marker_match_in   = marker_match_ff;
      chunked_seen_in   = chunked_seen_ff;
      space_count_in    = space_count_ff;
      status_digits_in  = status_digits_ff;
      status_stopped_in = status_stopped_ff;
      status_value_in   = status_value_ff;
      chunk_count_in    = chunk_count_ff;
      body_valid        = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            // status token: digits between the first and second space
            if (c == CHAR_SPACE) begin
               if (space_count_ff != 2'd2) begin
                  space_count_in = 2'(space_count_ff + 2'd1);
               end
            end else if (space_count_ff == 2'd1 && !status_stopped_ff) begin
               if (c >= "0" && c <= "9" && status_digits_ff < 2'(STATUS_MAX_DIGITS)) begin
                  status_value_in  = 10'(status_value_ff * 10'd10) + {6'd0, c[3:0]};
                  status_digits_in = 2'(status_digits_ff + 2'd1);
               end else begin
                  status_stopped_in = 1'b1;
               end
            end
            // chunked marker; its first letter appears nowhere else in it
            if (!chunked_seen_ff) begin
               if (c == marker_char(marker_match_ff)) begin
                  if (marker_match_ff == 5'(MARKER_LEN - 1)) begin
                     chunked_seen_in = 1'b1;
                     marker_match_in = 5'd0;
                  end else begin
                     marker_match_in = 5'(marker_match_ff + 5'd1);
                  end
               end else begin
                  marker_match_in = (c == marker_char(5'd0)) ? 5'd1 : 5'd0;
               end
            end
            // blank line ends the header
            if (c == end_char) begin
               if (end_match_ff == 2'd3) begin
                  end_match_in = 2'd0;
                  phase_in     = chunked_seen_in ? PH_SIZE_START : PH_PLAIN;
               end else begin
                  end_match_in = 2'(end_match_ff + 2'd1);
               end
            end else begin
               end_match_in = (c == CHAR_CR) ? 2'd1 : 2'd0;
            end
         end
         PH_PLAIN: begin
            body_valid = 1'b1;
         end
         PH_SIZE_START: begin
            // skip the line break left over from the previous chunk
            if (c != CHAR_CR && c != CHAR_LF) begin
               if (hex.hit) begin
                  chunk_count_in = {{(SIZE_BITS-HEX_RADIX_BITS){1'b0}}, hex.value};
                  phase_in       = PH_SIZE_DIGITS;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_SIZE_DIGITS: begin
            if (hex.hit) begin
               if (size_acc[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
                  chunk_count_in = '1;
               end else begin
                  chunk_count_in = size_acc[SIZE_BITS-1:0];
               end
            end else if (chunk_count_ff == '0) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = (c == CHAR_LF) ? PH_DATA : PH_SKIP_LF;
            end
         end
         PH_SKIP_LF: begin
            if (c == CHAR_LF) begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            body_valid = 1'b1;
            if (chunk_count_ff != '0) begin
               chunk_count_in = chunk_count_ff - SIZE_BITS'(1);
            end
            if (chunk_count_in == '0) begin
               phase_in = PH_SIZE_START;
            end
         end
         default: begin
            // done: drop everything up to the final byte
         end
      endcase

      // status fields show the state after this byte
      hdr_done  = phase_in != PH_HEADER;
      status_ok = hdr_done && space_count_in == 2'd2;
      rsp_data_in = {3'b000,
                     hdr_done && chunked_seen_in,
                     hdr_done,
                     status_ok,
                     status_ok ? status_value_in : 10'd0,
                     body_valid ? c : 8'h00};

      // the final byte rearms the parser for the next response
      if (req_tlast) begin
         phase_in          = PH_HEADER;
         end_match_in      = 2'd0;
         marker_match_in   = 5'd0;
         chunked_seen_in   = 1'b0;
         space_count_in    = 2'd0;
         status_digits_in  = 2'd0;
         status_stopped_in = 1'b0;
         status_value_in   = 10'd0;
         chunk_count_in    = '0;
      end
   end

   // advance the parser on every input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HEADER;
         end_match_ff      <= 2'd0;
         marker_match_ff   <= 5'd0;
         chunked_seen_ff   <= 1'b0;
         space_count_ff    <= 2'd0;
         status_digits_ff  <= 2'd0;
         status_stopped_ff <= 1'b0;
         status_value_ff   <= 10'd0;
         chunk_count_ff    <= '0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         end_match_ff      <= end_match_in;
         marker_match_ff   <= marker_match_in;
         chunked_seen_ff   <= chunked_seen_in;
         space_count_ff    <= space_count_in;
         status_digits_ff  <= status_digits_in;
         status_stopped_ff <= status_stopped_in;
         status_value_ff   <= status_value_in;
         chunk_count_ff    <= chunk_count_in;
      end
   end

   // result register: load when free or being drained, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= accept && (body_valid || req_tlast);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= body_valid;
         rsp_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/core/hrcd_checker.sv
// Port-level checks of the HTTP chunked response decoder, bound to its top.
`include "assert_macros.svh"

module hrcd_checker
   import hrcd_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [7:0]               req_tdata,
   input logic                     req_tlast,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tuser,
   input logic                     rsp_tlast
);

   logic unused_ok;
   assign unused_ok = ^req_tdata;

   // a stalled result holds
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // the final byte always yields a result in the next cycle
   `AST_NEXT(a_last_rsp, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid && rsp_tlast, "final byte gave no result")

   // a result carries a body byte or closes the response
   `AST_IMPL(a_rsp_cause, clock, reset, rsp_tvalid, rsp_tuser || rsp_tlast, "result without cause")

   // status and chunked flags only after the header end; no stray data
   `AST_IMPL(a_hdr_flags, clock, reset, rsp_tvalid && (rsp_tdata[18] || rsp_tdata[20]), rsp_tdata[19], "flag set before header end")

   `AST_IMPL(a_idle_byte, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[7:0] == 8'h00 && rsp_tdata[23:21] == 3'b000, "data bits set without body byte")

endmodule

bind http_response_chunked_decoder_top hrcd_checker u_hrcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
